// ----- sv/hcsp_pkg.sv -----
package hcsp_pkg;

   // Character that must open every color string.
   localparam logic [7:0] HASH_CHAR = 8'h23;

   // The character count saturates here.
   localparam logic [3:0] POS_LIMIT = 4'd10;

   // Digit counts that form a valid color.
   localparam logic [3:0] DIGITS_RGB      = 4'd3;
   localparam logic [3:0] DIGITS_ARGB     = 4'd4;
   localparam logic [3:0] DIGITS_RRGGBB   = 4'd6;
   localparam logic [3:0] DIGITS_AARRGGBB = 4'd8;

   // Opaque alpha values for the short and the long form.
   localparam logic [3:0] ALPHA_NIBBLE = 4'hF;
   localparam logic [7:0] ALPHA_BYTE   = 8'hFF;

   // Decoded hex character.
   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_digit_type;

   // Status of one string at its final character.
   typedef struct packed {
      logic       bad;
      logic [3:0] digits;
   } parse_status_type;

   // Decode one ASCII character as a hex digit, either case.
   function automatic hex_digit_type hex_value(input logic [7:0] c);
      hex_digit_type d;
      d.valid  = 1'b1;
      d.nibble = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         d.nibble = 4'(c - 8'h30);
      end else if (c inside {[8'h41:8'h46]}) begin
         d.nibble = 4'(c - 8'h41 + 8'd10);
      end else if (c inside {[8'h61:8'h66]}) begin
         d.nibble = 4'(c - 8'h61 + 8'd10);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   // Repeat every nibble of a 16-bit ARGB word to form a 32-bit color.
   function automatic logic [31:0] double_nibbles(input logic [15:0] four);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[i*8 +: 8] = {four[i*4 +: 4], four[i*4 +: 4]};
      end
      return r;
   endfunction

endpackage

// ----- sv/hcsp_color_build.sv -----
module hcsp_color_build (
   input  logic [31:0]                 gather,
   input  hcsp_pkg::parse_status_type  status,
   output logic                        ok,
   output logic [31:0]                 color
);

   // Expand the gathered digits according to how many there were.
   always_comb begin
      ok    = 1'b0;
      color = gather;
      case (status.digits)
         hcsp_pkg::DIGITS_RGB: begin
            ok    = 1'b1;
            color = hcsp_pkg::double_nibbles({hcsp_pkg::ALPHA_NIBBLE, gather[11:0]});
         end
         hcsp_pkg::DIGITS_ARGB: begin
            ok    = 1'b1;
            color = hcsp_pkg::double_nibbles(gather[15:0]);
         end
         hcsp_pkg::DIGITS_RRGGBB: begin
            ok    = 1'b1;
            color = {hcsp_pkg::ALPHA_BYTE, gather[23:0]};
         end
         hcsp_pkg::DIGITS_AARRGGBB: begin
            ok    = 1'b1;
            color = gather;
         end
         default: begin
            ok    = 1'b0;
            color = gather;
         end
      endcase
      // A wrong character anywhere fails the whole string.
      if (status.bad) begin
         ok = 1'b0;
      end
   end

endmodule

// ----- sv/hex_color_string_parser_core.sv -----
// Hex color string parser.
// Requests arrive on the req_ channel one character at a time; req_tlast
// marks the final character of a string. The string must be '#' followed by
// 3, 4, 6 or 8 hex digits (either case). For each string one response leaves
// on the rsp_ channel when its last character has been processed: rsp_tuser
// is 1 if the string was valid, and rsp_tdata carries the stored ARGB color,
// which a valid string replaces and a failed string leaves unchanged.
// Characters before the last produce no response.
// Pipeline: a request is registered in the input register and processed from
// there; its response is registered in the output register before it appears
// on rsp_. Throughput is one character per cycle unless a last character waits
// for the output register; the only loop is the per-string state update (count,
// digit shift, error flag), computed combinationally from the input register.
// Reset clears the string state, the stored color (to zero) and both
// pipeline stages. When the receiver holds rsp_tready low, a waiting
// response stays in the output register; non-last characters still flow,
// and the input stalls only once a last character waits behind it.
module hex_color_string_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] color
   output logic        rsp_tuser    // [0] ok
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_ch_ff;
   logic        in_last_ff;
   logic        in_move;
   logic        out_free;

   logic [3:0]  pos_ff, pos_in;
   logic [31:0] gather_ff, gather_in;
   logic        bad_ff, bad_in;
   logic [31:0] stored_ff, stored_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_color_ff;
   logic        rsp_ok_ff;

   logic [31:0]                gather_next;
   logic                       bad_next;
   logic [3:0]                 pos_next;
   hcsp_pkg::hex_digit_type    digit;
   hcsp_pkg::parse_status_type status;
   logic                       build_ok;
   logic [31:0]                build_color;

   // Handshake: a stored character moves on unless it is last and the
   // output register is still occupied.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_move    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || in_move;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Per-character update of the string state.
   always_comb begin
      digit       = hcsp_pkg::hex_value(in_ch_ff);
      gather_next = gather_ff;
      bad_next    = bad_ff;
      if (pos_ff == 4'd0) begin
         if (in_ch_ff != hcsp_pkg::HASH_CHAR) begin
            bad_next = 1'b1;
         end
      end else if (!digit.valid) begin
         bad_next = 1'b1;
      end else begin
         gather_next = {gather_ff[27:0], digit.nibble};
      end
      pos_next = (pos_ff < hcsp_pkg::POS_LIMIT) ? pos_ff + 4'd1 : pos_ff;
      status.bad    = bad_next;
      status.digits = pos_next - 4'd1;
   end

   hcsp_color_build u_build (
      .gather (gather_next),
      .status (status),
      .ok     (build_ok),
      .color  (build_color)
   );

   // Next values of the string state, the stored color and the response.
   always_comb begin
      pos_in       = pos_ff;
      gather_in    = gather_ff;
      bad_in       = bad_ff;
      stored_in    = stored_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (in_move) begin
         if (in_last_ff) begin
            pos_in       = 4'd0;
            gather_in    = '0;
            bad_in       = 1'b0;
            rsp_valid_in = 1'b1;
            if (build_ok) begin
               stored_in = build_color;
            end
         end else begin
            pos_in    = pos_next;
            gather_in = gather_next;
            bad_in    = bad_next;
         end
      end
   end

   // State and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         gather_ff    <= '0;
         bad_ff       <= 1'b0;
         stored_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         gather_ff    <= gather_in;
         bad_ff       <= bad_in;
         stored_ff    <= stored_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move && in_last_ff) begin
         rsp_ok_ff    <= build_ok;
         rsp_color_ff <= stored_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_color_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule
